FILE: src/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and helpers for the differential-drive odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CNT_W        = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam int RADIUS_W = 18;
   localparam int INVB_W   = 24;
   localparam int CSR_W    = 24;

   // csr register indexes
   localparam logic CSR_RADIUS       = 1'b0;
   localparam logic CSR_INVERSE_BASE = 1'b1;

   // radians (Q16.16) to binary angle, scaled by 2^16
   localparam logic [29:0] BAM_PER_RAD_Q16 = 30'd683565276;
   // cordic start value, limit gain in Q4.30
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 18'd65536;
   localparam logic [INVB_W-1:0]   INVB_RESET   = 24'd65536;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic signed [MUL_A_W-1:0] mul_a_type;
   typedef logic signed [MUL_B_W-1:0] mul_b_type;
   typedef logic signed [MUL_P_W-1:0] mul_p_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic [29:0] atan_bam(input logic [4:0] idx);
      logic [29:0] r;
      unique case (idx)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: src/diff_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Wheel odometry with midpoint pose integration, one shared multiplier and an
// iterative cordic under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  fields
//  req      in   func, left_angle, right_angle, left_rate, right_rate
//  rsp      out  pos_x, pos_y, heading, lin_speed, turn_rate
//  csr      in   radius (0), inverse base (1)
//
//  an update beat uses the shared 35x26 multiplier and the cordic loop for the
//  pose step, then the multiplier again for the rates, before rsp_valid;
//  a clear beat shows its result in the next cycle.
//  req_stall is high from accept until the result beat is taken.
//  reset restores the registers to 1.0 and zeroes the pose state.
//  rsp_stall only holds the finished result; the pose stays put meanwhile.
module diff_drive_odometry_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_left_angle,
   input  logic [31:0] req_right_angle,
   input  logic [31:0] req_left_rate,
   input  logic [31:0] req_right_rate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_heading,
   output logic [31:0] rsp_lin_speed,
   output logic [31:0] rsp_turn_rate,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [ddo_pkg::CSR_W-1:0] csr_data
);
   import ddo_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_PREP  = 5'd1;
   localparam logic [4:0] S_MSUM  = 5'd2;
   localparam logic [4:0] S_MDIF  = 5'd3;
   localparam logic [4:0] S_TRND  = 5'd4;
   localparam logic [4:0] S_MANG  = 5'd5;
   localparam logic [4:0] S_ARND  = 5'd6;
   localparam logic [4:0] S_MKLO  = 5'd7;
   localparam logic [4:0] S_MKHI  = 5'd8;
   localparam logic [4:0] S_PSUM  = 5'd9;
   localparam logic [4:0] S_DIR   = 5'd10;
   localparam logic [4:0] S_CINIT = 5'd11;
   localparam logic [4:0] S_CROT  = 5'd12;
   localparam logic [4:0] S_CFIN  = 5'd13;
   localparam logic [4:0] S_MX    = 5'd14;
   localparam logic [4:0] S_MY    = 5'd15;
   localparam logic [4:0] S_ACCY  = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;

   logic [4:0]          state_ff, state_in;
   logic [RADIUS_W-1:0] radius_ff;
   logic [INVB_W-1:0]   invb_ff;

   logic [31:0] acc_x_ff, acc_y_ff, acc_head_ff, prev_l_ff, prev_r_ff;
   logic [31:0] lin_speed_ff, turn_rate_ff;
   logic        vel_ff;

   logic signed [31:0] dl_ff, dr_ff, lrate_ff, rrate_ff;
   logic signed [32:0] sum_ff, dif_ff;
   logic signed [34:0] lin_ff, t_ff;
   logic signed [43:0] ang_ff;
   logic [48:0]        plo_ff, p_ff;
   logic [31:0]        dir_ff, hstep_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic signed [25:0] c_ff, s_ff;
   mul_p_type          prod_ff;

   mul_a_type mul_a;
   mul_b_type mul_b;

   // rounded views of the product
   logic signed [MUL_P_W-1:0] prod_r15, prod_r16, prod_r23;
   logic signed [34:0]        rnd17, rnd16_t;
   logic signed [43:0]        rnd16_a;
   logic signed [36:0]        rnd24;
   logic signed [48:0]        ang49;
   logic [48:0]               p_sum, p_r15, p_r16;
   logic signed [37:0]        new_x, new_y;

   // cordic step
   logic signed [33:0] xs, ys, x_neg, y_neg, xe, ye, xr, yr;
   logic [31:0]        fold;
   logic [29:0]        atan_cur;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   assign rsp_pos_x     = acc_x_ff;
   assign rsp_pos_y     = acc_y_ff;
   assign rsp_heading   = acc_head_ff;
   assign rsp_lin_speed = lin_speed_ff;
   assign rsp_turn_rate = turn_rate_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MSUM: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = {{(MUL_B_W-RADIUS_W){1'b0}}, radius_ff};
         end
         S_MDIF: begin
            mul_a = MUL_A_W'(dif_ff);
            mul_b = {{(MUL_B_W-RADIUS_W){1'b0}}, radius_ff};
         end
         S_MANG: begin
            mul_a = t_ff;
            mul_b = {{(MUL_B_W-INVB_W){1'b0}}, invb_ff};
         end
         S_MKLO: begin
            mul_a = {5'b0, BAM_PER_RAD_Q16};
            mul_b = {2'b0, ang49[23:0]};
         end
         S_MKHI: begin
            mul_a = {5'b0, BAM_PER_RAD_Q16};
            mul_b = {1'b0, ang49[48:24]};
         end
         S_MX: begin
            mul_a = lin_ff;
            mul_b = c_ff;
         end
         S_MY: begin
            mul_a = lin_ff;
            mul_b = s_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_r15 = prod_ff + MUL_P_W'(32768);
   assign prod_r16 = prod_ff + MUL_P_W'(65536);
   assign prod_r23 = prod_ff + MUL_P_W'(8388608);
   assign rnd17    = prod_r16[51:17];
   assign rnd16_t  = prod_r15[50:16];
   assign rnd16_a  = prod_r15[59:16];
   assign rnd24    = prod_r23[60:24];

   assign ang49 = 49'(ang_ff);
   assign p_sum = plo_ff + {prod_ff[24:0], 24'b0};
   assign p_r15 = p_ff + 49'd32768;
   assign p_r16 = p_ff + 49'd65536;

   assign new_x = 38'(signed'(acc_x_ff)) + 38'(rnd24);
   assign new_y = 38'(signed'(acc_y_ff)) + 38'(rnd24);

   assign xs       = x_ff >>> cnt_ff;
   assign ys       = y_ff >>> cnt_ff;
   assign atan_cur = atan_bam(5'(cnt_ff));
   assign fold     = dir_ff + 32'h4000_0000;
   assign x_neg    = -x_ff;
   assign y_neg    = -y_ff;
   assign xe       = (flip_ff ? x_neg : x_ff) + 34'sd32;
   assign ye       = (flip_ff ? y_neg : y_ff) + 34'sd32;
   assign xr       = z_ff[33] ? (x_ff + ys) : (x_ff - ys);
   assign yr       = z_ff[33] ? (y_ff - xs) : (y_ff + xs);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = req_func ? S_OUT : S_PREP;
            end
         end
         S_PREP:  state_in = S_MSUM;
         S_MSUM:  state_in = S_MDIF;
         S_MDIF:  state_in = S_TRND;
         S_TRND:  state_in = S_MANG;
         S_MANG:  state_in = S_ARND;
         S_ARND:  state_in = vel_ff ? S_OUT : S_MKLO;
         S_MKLO:  state_in = S_MKHI;
         S_MKHI:  state_in = S_PSUM;
         S_PSUM:  state_in = S_DIR;
         S_DIR:   state_in = S_CINIT;
         S_CINIT: state_in = S_CROT;
         S_CROT: begin
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = S_CFIN;
            end
         end
         S_CFIN:  state_in = S_MX;
         S_MX:    state_in = S_MY;
         S_MY:    state_in = S_ACCY;
         S_ACCY:  state_in = S_PREP;
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= RADIUS_RESET;
         invb_ff      <= INVB_RESET;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_head_ff  <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         lin_speed_ff <= '0;
         turn_rate_ff <= '0;
         vel_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_RADIUS:       radius_ff <= csr_data[RADIUS_W-1:0];
               CSR_INVERSE_BASE: invb_ff   <= csr_data[INVB_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_valid) begin
            vel_ff <= 1'b0;
            if (req_func) begin
               acc_x_ff     <= '0;
               acc_y_ff     <= '0;
               acc_head_ff  <= '0;
               prev_l_ff    <= '0;
               prev_r_ff    <= '0;
               lin_speed_ff <= '0;
               turn_rate_ff <= '0;
            end else begin
               prev_l_ff <= req_left_angle;
               prev_r_ff <= req_right_angle;
            end
         end
         if (state_ff == S_ARND && vel_ff) begin
            lin_speed_ff <= sat32(64'(lin_ff));
            turn_rate_ff <= sat32(64'(rnd16_a));
         end
         if (state_ff == S_MY) begin
            acc_x_ff <= sat32(64'(new_x));
         end
         if (state_ff == S_ACCY) begin
            acc_y_ff    <= sat32(64'(new_y));
            acc_head_ff <= acc_head_ff + hstep_ff;
            vel_ff      <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_IDLE && req_valid) begin
         dl_ff    <= signed'(req_left_angle - prev_l_ff);
         dr_ff    <= signed'(req_right_angle - prev_r_ff);
         lrate_ff <= signed'(req_left_rate);
         rrate_ff <= signed'(req_right_rate);
      end
      unique case (state_ff)
         S_PREP: begin
            sum_ff <= 33'(dl_ff) + 33'(dr_ff);
            dif_ff <= 33'(dr_ff) - 33'(dl_ff);
         end
         S_MDIF:  lin_ff <= rnd17;
         S_TRND:  t_ff   <= rnd16_t;
         S_ARND:  ang_ff <= rnd16_a;
         S_MKHI:  plo_ff <= prod_ff[48:0];
         S_PSUM:  p_ff   <= p_sum;
         S_DIR: begin
            dir_ff   <= acc_head_ff + p_r16[48:17];
            hstep_ff <= p_r15[47:16];
         end
         S_CINIT: begin
            // fold into the right half plane, undo with a sign flip
            flip_ff <= fold[31];
            z_ff    <= 34'(signed'(fold[31] ? (dir_ff ^ 32'h8000_0000) : dir_ff));
            x_ff    <= CORDIC_GAIN_Q30;
            y_ff    <= '0;
            cnt_ff  <= '0;
         end
         S_CROT: begin
            x_ff   <= xr;
            y_ff   <= yr;
            z_ff   <= z_ff[33] ? (z_ff + signed'({4'b0, atan_cur}))
                               : (z_ff - signed'({4'b0, atan_cur}));
            cnt_ff <= cnt_ff + 1'b1;
         end
         S_CFIN: begin
            c_ff <= xe[31:6];
            s_ff <= ye[31:6];
         end
         S_ACCY: begin
            dl_ff <= lrate_ff;
            dr_ff <= rrate_ff;
         end
         default: ;
      endcase
   end

endmodule
